// ===== rtl/dit_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes for the disjoint interval tracker: opcodes and result kinds.
package dit_pkg;

    localparam int KIND_W = 3;
    localparam int COUNT_W = 6;
    localparam int OUT_VALUE_W = 32;
    localparam int IN_VALUE_W = 32;

    typedef logic [KIND_W-1:0] kind_t;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    localparam kind_t K_ADDED = 3'd0;
    localparam kind_t K_PRESENT = 3'd1;
    localparam kind_t K_FULL = 3'd2;
    localparam kind_t K_RECORD = 3'd3;
    localparam kind_t K_EMPTY = 3'd4;

endpackage

// ===== rtl/dit_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module dit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/disjoint_interval_tracker.sv =====
`timescale 1ns / 1ps
// Top level: sorted table of disjoint intervals with a scan/shift sequencer.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   opcode, value
//   out      from block out_valid/out_stall kind, interval_start, interval_end,
//                                           interval_count, last
//
// Add: linear scan of the table, one entry per cycle through the RAM read port,
// then a decision state, then a shift of the tail one entry per cycle, then the
// status transaction; the scan and the shift share the single RAM port pair.
// Dump: one record per cycle while out_stall is low, after a registered RAM read.
// Reset clears the interval count and the sequencer; the RAM is not cleared,
// since only entries below the count are ever read.
// in_stall is high whenever the sequencer is busy; a stalled result is held in
// the output register while the next transaction is already accepted.
module disjoint_interval_tracker
    import dit_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [IN_VALUE_W-1:0]  value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output kind_t                  kind,
    output logic [OUT_VALUE_W-1:0] interval_start,
    output logic [OUT_VALUE_W-1:0] interval_end,
    output logic [COUNT_W-1:0]     interval_count,
    output logic                   last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = 2 * VALUE_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;
    localparam logic [2:0] S_DUMP = 3'd5;

    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [ENTRY_W-1:0]    prev_reg, prev_next;
    logic [ENTRY_W-1:0]    nxt_reg, nxt_next;
    logic                  has_prev_reg, has_prev_next;
    logic                  has_nxt_reg, has_nxt_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  up_reg, up_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      wa_reg, wa_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    kind_t                 kind_reg, kind_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [OUT_VALUE_W-1:0] out_start_reg, out_start_next;
    logic [OUT_VALUE_W-1:0] out_end_reg, out_end_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

    logic                  in_take, out_free;
    logic [VALUE_BITS-1:0] rd_start, prev_start, prev_end, nxt_start, nxt_end;
    logic                  present, touch_prev, touch_nxt;
    logic [CNT_W-1:0]      pos_p1, pos_m1, ptr_p1, ptr_m1;

    dit_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign rd_start = ram_rdata[ENTRY_W-1:VALUE_BITS];
    assign prev_start = prev_reg[ENTRY_W-1:VALUE_BITS];
    assign prev_end = prev_reg[VALUE_BITS-1:0];
    assign nxt_start = nxt_reg[ENTRY_W-1:VALUE_BITS];
    assign nxt_end = nxt_reg[VALUE_BITS-1:0];

    // Neighbor tests are one bit wider so they never wrap at the value edges.
    assign present = has_prev_reg && (prev_end >= v_reg);
    assign touch_prev = has_prev_reg && (({1'b0, prev_end} + 1'b1) == {1'b0, v_reg});
    assign touch_nxt = has_nxt_reg && ({1'b0, nxt_start} == ({1'b0, v_reg} + 1'b1));

    assign pos_p1 = pos_reg + ONE;
    assign pos_m1 = pos_reg - ONE;
    assign ptr_p1 = ptr_reg + ONE;
    assign ptr_m1 = ptr_reg - ONE;

    always_comb
    begin
        state_next = state_reg;
        v_next = v_reg;
        prev_next = prev_reg;
        nxt_next = nxt_reg;
        has_prev_next = has_prev_reg;
        has_nxt_next = has_nxt_reg;
        pos_next = pos_reg;
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        up_next = up_reg;
        pend_next = pend_reg;
        wa_next = wa_reg;
        total_next = total_reg;
        kind_next = kind_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_kind_next = out_kind_reg;
        out_start_next = out_start_reg;
        out_end_next = out_end_reg;
        out_count_next = out_count_reg;
        out_last_next = out_last_reg;

        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_re = 1'b0;
        ram_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    v_next = VALUE_BITS'(value);
                    has_prev_next = 1'b0;
                    has_nxt_next = 1'b0;
                    pos_next = '0;
                    if (total_reg == '0)
                    begin
                        // Empty table: nothing to scan.
                        kind_next = K_EMPTY;
                        state_next = (opcode == OP_DUMP) ? S_RESP : S_DECIDE;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                        state_next = (opcode == OP_DUMP) ? S_DUMP : S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_start > v_reg)
                begin
                    nxt_next = ram_rdata;
                    has_nxt_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                begin
                    prev_next = ram_rdata;
                    has_prev_next = 1'b1;
                    pos_next = pos_p1;
                    if (pos_p1 == total_reg)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                        ram_raddr = pos_p1[IDX_W-1:0];
                    end
                end
            end

            S_DECIDE:
            begin
                kind_next = K_ADDED;
                state_next = S_RESP;
                if (present)
                begin
                    kind_next = K_PRESENT;
                end
                else if (touch_prev && touch_nxt)
                begin
                    // Merge: widen the lower interval, then pull the tail down.
                    ram_we = 1'b1;
                    ram_waddr = pos_m1[IDX_W-1:0];
                    ram_wdata = {prev_start, nxt_end};
                    cnt_next = total_reg - pos_p1;
                    ptr_next = pos_p1;
                    up_next = 1'b0;
                    pend_next = 1'b0;
                    total_next = total_reg - ONE;
                    state_next = S_SHIFT;
                end
                else if (touch_prev)
                begin
                    ram_we = 1'b1;
                    ram_waddr = pos_m1[IDX_W-1:0];
                    ram_wdata = {prev_start, v_reg};
                end
                else if (touch_nxt)
                begin
                    ram_we = 1'b1;
                    ram_waddr = pos_reg[IDX_W-1:0];
                    ram_wdata = {v_reg, nxt_end};
                end
                else if (total_reg >= CAP)
                begin
                    kind_next = K_FULL;
                end
                else
                begin
                    // New interval: push the tail up, then write the slot.
                    cnt_next = total_reg - pos_reg;
                    ptr_next = total_reg - ONE;
                    up_next = 1'b1;
                    pend_next = 1'b0;
                    total_next = total_reg + ONE;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Write the entry read last cycle while the next one is read.
                ram_we = pend_reg;
                ram_waddr = wa_reg;
                ram_wdata = ram_rdata;
                if (cnt_reg != '0)
                begin
                    ram_re = 1'b1;
                    ram_raddr = ptr_reg[IDX_W-1:0];
                    wa_next = up_reg ? ptr_p1[IDX_W-1:0] : ptr_m1[IDX_W-1:0];
                    ptr_next = up_reg ? ptr_m1 : ptr_p1;
                    cnt_next = cnt_reg - ONE;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (up_reg)
                        begin
                            ram_we = 1'b1;
                            ram_waddr = pos_reg[IDX_W-1:0];
                            ram_wdata = {v_reg, v_reg};
                        end
                        state_next = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next = kind_reg;
                    out_start_next = '0;
                    out_end_next = '0;
                    out_count_next = COUNT_W'(total_reg);
                    out_last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DUMP:
            begin
                // Read data holds while the output register is busy.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next = K_RECORD;
                    out_start_next = OUT_VALUE_W'(rd_start);
                    out_end_next = OUT_VALUE_W'(ram_rdata[VALUE_BITS-1:0]);
                    out_count_next = COUNT_W'(total_reg);
                    out_last_next = (pos_p1 == total_reg);
                    if (pos_p1 == total_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                        ram_raddr = pos_p1[IDX_W-1:0];
                        pos_next = pos_p1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        prev_reg <= prev_next;
        nxt_reg <= nxt_next;
        has_prev_reg <= has_prev_next;
        has_nxt_reg <= has_nxt_next;
        pos_reg <= pos_next;
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
        up_reg <= up_next;
        wa_reg <= wa_next;
        kind_reg <= kind_next;
        out_kind_reg <= out_kind_next;
        out_start_reg <= out_start_next;
        out_end_reg <= out_end_next;
        out_count_reg <= out_count_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind = out_kind_reg;
    assign interval_start = out_start_reg;
    assign interval_end = out_end_reg;
    assign interval_count = out_count_reg;
    assign last = out_last_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CAP)
        else $error("interval count above capacity");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg == $past(total_reg)) || (total_reg == $past(total_reg) + ONE)
                 || (total_reg + ONE == $past(total_reg)))
        else $error("interval count moved by more than one");

    a_shift_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (cnt_reg <= total_reg))
        else $error("shift span exceeds table");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> (out_valid_reg && out_last_reg))
        else $error("status transaction not loaded");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the disjoint interval tracker: directed table, random adds and dumps.
module tb;
    import dit_pkg::*;

    localparam int CAP = 32;
    localparam int RANDOM_ITEMS = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        kind_t             kind;
        logic [31:0]       first_val;
        logic [31:0]       last_val;
        logic [COUNT_W-1:0] count;
        logic              is_last;
    } status_t;

    // Directed row: opcode, value, and an optional hand-typed expectation.
    typedef struct {
        logic        op;
        logic [31:0] val;
        bit          typed;
        kind_t       kind;
        int          count;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic opcode;
    logic [31:0] value;
    logic out_valid;
    logic out_stall;
    kind_t kind;
    logic [31:0] interval_start;
    logic [31:0] interval_end;
    logic [COUNT_W-1:0] interval_count;
    logic last;

    disjoint_interval_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .interval_start(interval_start), .interval_end(interval_end),
        .interval_count(interval_count), .last(last)
    );

    // Predictor state: sorted interval bounds and how many are stored.
    logic [31:0] lo_tab[CAP];
    logic [31:0] hi_tab[CAP];
    int          span_total;

    status_t expected_q[$];
    int      error_count;
    int      idle_cycles;
    bit      stim_done;
    bit      timed_out;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Insert one value into the predicted table and return the status kind.
    function automatic kind_t insert_value(input logic [31:0] v);
        int  i;
        bit  near_lo;
        bit  near_hi;
        i = 0;
        while (i < span_total && lo_tab[i] <= v)
            i++;
        if (i > 0 && hi_tab[i-1] >= v)
            return K_PRESENT;
        // no wrap: hi_tab[i-1] < v, lo_tab[i] > v
        near_lo = (i > 0) && (hi_tab[i-1] + 32'd1 == v);
        near_hi = (i < span_total) && (lo_tab[i] == v + 32'd1);
        if (near_lo && near_hi) begin
            hi_tab[i-1] = hi_tab[i];
            for (int j = i; j + 1 < span_total; j++) begin
                lo_tab[j] = lo_tab[j+1];
                hi_tab[j] = hi_tab[j+1];
            end
            span_total--;
            return K_ADDED;
        end
        if (near_lo) begin
            hi_tab[i-1] = v;
            return K_ADDED;
        end
        if (near_hi) begin
            lo_tab[i] = v;
            return K_ADDED;
        end
        if (span_total >= CAP)
            return K_FULL;
        for (int j = span_total; j > i; j--) begin
            lo_tab[j] = lo_tab[j-1];
            hi_tab[j] = hi_tab[j-1];
        end
        lo_tab[i] = v;
        hi_tab[i] = v;
        span_total++;
        return K_ADDED;
    endfunction

    // Queue up the results one input transaction must produce.
    function automatic void predict_results(input logic op, input logic [31:0] v);
        status_t r;
        if (op == OP_ADD) begin
            r.kind = insert_value(v);
            r.first_val = '0;
            r.last_val = '0;
            r.count = span_total[COUNT_W-1:0];
            r.is_last = 1'b1;
            expected_q.insert(expected_q.size(), r);
        end else if (span_total == 0) begin
            r = '{K_EMPTY, 32'd0, 32'd0, '0, 1'b1};
            expected_q.insert(expected_q.size(), r);
        end else begin
            for (int k = 0; k < span_total; k++) begin
                r.kind = K_RECORD;
                r.first_val = lo_tab[k];
                r.last_val = hi_tab[k];
                r.count = span_total[COUNT_W-1:0];
                r.is_last = (k + 1 == span_total);
                expected_q.insert(expected_q.size(), r);
            end
        end
    endfunction

    // Pick a gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one transaction and hold it until it is accepted; valid stays
    // high afterwards only when the next transaction follows with no gap.
    task automatic send_item(input logic op, input logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode <= op;
        value <= v;
        in_valid <= 1'b1;
        predict_results(op, v);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random add value: mostly near existing intervals so merges happen,
    // sometimes fully random or at the value edges.
    function automatic logic [31:0] pick_value(input int base);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return base + $urandom_range(0, 90);
        if (roll < 80)
            return $urandom_range(0, 6);
        if (roll < 90)
            return 32'hFFFF_FFFF - $urandom_range(0, 6);
        return $urandom();
    endfunction

    // Check every result transaction against the oldest expectation.
    always @(posedge clk) begin
        status_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_q.pop_front();
                // compare field by field
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d want %0d", kind, want.kind));
                if (interval_start !== want.first_val)
                    report_mismatch($sformatf("start %0h want %0h",
                        interval_start, want.first_val));
                if (interval_end !== want.last_val)
                    report_mismatch($sformatf("end %0h want %0h",
                        interval_end, want.last_val));
                if (interval_count !== want.count)
                    report_mismatch($sformatf("count %0d want %0d",
                        interval_count, want.count));
                if (last !== want.is_last)
                    report_mismatch($sformatf("last %0b want %0b", last, want.is_last));
            end
        end
    end

    // Randomly stall the output: long stretches without stalls, then bursts.
    initial begin
        out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(5, 60)) @(posedge clk);
            repeat ($urandom_range(5, 60)) begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < 30);
            end
            if ($urandom_range(0, 9) == 0) begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        row_t plan[$];
        int   base;
        int   waited;
        in_valid = 1'b0;
        opcode = OP_ADD;
        value = '0;
        rst_n = 1'b0;
        span_total = 0;
        error_count = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        timed_out = 1'b0;

        // Directed rows: empty dump, value edges, extend, merge, present.
        plan.insert(plan.size(), '{OP_DUMP, 32'h1234_5678, 1, K_EMPTY, 0});
        plan.insert(plan.size(), '{OP_ADD, 32'd0, 1, K_ADDED, 1});
        plan.insert(plan.size(), '{OP_ADD, 32'hFFFF_FFFF, 1, K_ADDED, 2});
        plan.insert(plan.size(), '{OP_ADD, 32'd0, 1, K_PRESENT, 2});
        plan.insert(plan.size(), '{OP_ADD, 32'hFFFF_FFFE, 1, K_ADDED, 2});
        plan.insert(plan.size(), '{OP_ADD, 32'd2, 1, K_ADDED, 3});
        plan.insert(plan.size(), '{OP_ADD, 32'd1, 1, K_ADDED, 2});
        plan.insert(plan.size(), '{OP_ADD, 32'hAAAA_5555, 0, K_ADDED, 0});
        plan.insert(plan.size(), '{OP_ADD, 32'h5555_AAAA, 0, K_ADDED, 0});
        plan.insert(plan.size(), '{OP_ADD, 32'h5555_AAAB, 0, K_ADDED, 0});
        plan.insert(plan.size(), '{OP_DUMP, 32'd0, 0, K_RECORD, 0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                while (idle_cycles < WATCHDOG_LIMIT)
                    @(posedge clk);
                timed_out = 1'b1;
            end
            begin
                foreach (plan[n]) begin
                    send_item(plan[n].op, plan[n].val);
                    if (plan[n].typed) begin
                        // overwrite the predicted entry with the typed-in value
                        expected_q[expected_q.size()-1] = '{plan[n].kind, 32'd0, 32'd0,
                            plan[n].count[COUNT_W-1:0], 1'b1};
                    end
                end
                // Fill the table with isolated values so it goes full, then
                // try a new value, two extensions and a merge at capacity.
                for (int n = 0; n < 40; n++)
                    send_item(OP_ADD, 32'h1000 + 4 * n);
                send_item(OP_ADD, 32'h0800_0000);
                send_item(OP_ADD, 32'h1001);
                send_item(OP_ADD, 32'h1003);
                send_item(OP_ADD, 32'h1002);
                send_item(OP_DUMP, $urandom());
                // Random part: evolving values with a dump now and then.
                base = $urandom_range(100, 1000);
                for (int n = 0; n < RANDOM_ITEMS; n++) begin
                    if ($urandom_range(0, 99) < 8)
                        send_item(OP_DUMP, $urandom());
                    else
                        send_item(OP_ADD, pick_value(base));
                    if ($urandom_range(0, 99) < 3)
                        base = $urandom_range(100, 1000) * 100;
                end
                send_item(OP_DUMP, 32'd0);
                in_valid <= 1'b0;
                waited = 0;
                while (expected_q.size() != 0)
                    @(posedge clk);
                while (waited < 100) begin
                    @(posedge clk);
                    waited++;
                end
                stim_done = 1'b1;
            end
        join_any
        disable fork;

        if (timed_out) begin
            $display("FAIL");
        end else begin
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
            if (error_count == 0)
                $display("PASS");
            else
                $display("FAIL");
        end
        $finish;
    end
endmodule
